>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/cset_pkg.sv
// ----------------------------------------------------------------------------
// cset_pkg
// Shared constants, types and codes of the call stack exclusive time core.
// ----------------------------------------------------------------------------
`default_nettype none

package cset_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int TIME_BITS   = 16;
    localparam int ID_W        = 8;
    localparam int STATUS_W    = 3;
    localparam int CALLEE_W    = TIME_BITS + 1;
    localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int S_TDATA_W   = ((ID_W + TIME_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((ID_W + CALLEE_W + 7) / 8) * 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_STARTED  = 3'd0,
        ST_FINISHED = 3'd1,
        ST_MISMATCH = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_ORDER    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LOAD = 3'b100
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [TIME_BITS-1:0] start;
        logic [CALLEE_W-1:0]  callee;
    } frame_t;

    typedef struct packed {
        logic load_in;
        logic commit;
        logic load_parent;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic need_parent;
    } stat_t;

endpackage

`default_nettype wire

>>> src/cset_ctrl.sv
// ----------------------------------------------------------------------------
// cset_ctrl
// Sequencer of the call stack core: capture, evaluate and commit, parent load.
// ----------------------------------------------------------------------------
`default_nettype none

module cset_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire cset_pkg::stat_t stat,
    output cset_pkg::cmd_t       cmd
);

    cset_pkg::state_t state_reg;
    cset_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cset_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        s_tready        = 1'b0;
        case (state_reg)
            cset_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = cset_pkg::S_EXEC;
                end
            end
            cset_pkg::S_EXEC:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = stat.need_parent ? cset_pkg::S_LOAD : cset_pkg::S_IDLE;
                end
            end
            cset_pkg::S_LOAD:
            begin
                cmd.load_parent = 1'b1;
                state_next      = cset_pkg::S_IDLE;
            end
            default:
            begin
                state_next = cset_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/cset_dp.sv
// ----------------------------------------------------------------------------
// cset_dp
// Datapath: event capture, cached top frame, frame memory, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cset_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [cset_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [cset_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [cset_pkg::STATUS_W-1:0]       m_tuser,
    input  wire cset_pkg::cmd_t                 cmd,
    output cset_pkg::stat_t                     stat
);

    localparam int LVL_W    = cset_pkg::LVL_W;
    localparam int ADDR_W   = cset_pkg::ADDR_W;
    localparam int CALLEE_W = cset_pkg::CALLEE_W;
    localparam int TIME_W   = cset_pkg::TIME_BITS;
    localparam int ID_W     = cset_pkg::ID_W;

    cset_pkg::frame_t mem [cset_pkg::STACK_DEPTH];
    cset_pkg::frame_t rd_data_reg;
    cset_pkg::frame_t top_reg;

    logic                 op_reg;
    logic [ID_W-1:0]      id_reg;
    logic [TIME_W-1:0]    ts_reg;
    logic [LVL_W-1:0]     level_reg;
    logic [CALLEE_W-1:0]  incl_reg;

    logic                 out_valid_reg;
    cset_pkg::status_t    out_status_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic [CALLEE_W-1:0]  out_excl_reg;

    logic                 empty;
    logic                 full;
    logic                 early;
    logic                 short;
    logic [CALLEE_W-1:0]  incl;
    logic [CALLEE_W-1:0]  excl;
    logic [LVL_W-1:0]     lvl_m1;
    logic [LVL_W-1:0]     lvl_m2;
    logic                 push;
    logic                 pop;
    cset_pkg::status_t    status;
    logic [CALLEE_W:0]    sum;
    logic [CALLEE_W-1:0]  callee_sat;

    assign empty  = (level_reg == '0);
    assign full   = (level_reg == LVL_W'(cset_pkg::STACK_DEPTH));
    assign early  = (ts_reg < top_reg.start);
    assign incl   = {1'b0, ts_reg} - {1'b0, top_reg.start} + CALLEE_W'(1);
    assign short  = (incl < top_reg.callee);
    assign excl   = incl - top_reg.callee;
    assign lvl_m1 = level_reg - LVL_W'(1);
    assign lvl_m2 = level_reg - LVL_W'(2);

    always_comb
    begin
        push   = 1'b0;
        pop    = 1'b0;
        status = cset_pkg::ST_STARTED;
        if (!op_reg)
        begin
            if (full)
            begin
                status = cset_pkg::ST_OVERFLOW;
            end
            else if (!empty && early)
            begin
                status = cset_pkg::ST_ORDER;
            end
            else
            begin
                push = 1'b1;
            end
        end
        else
        begin
            if (empty)
            begin
                status = cset_pkg::ST_EMPTY;
            end
            else if (top_reg.id != id_reg)
            begin
                status = cset_pkg::ST_MISMATCH;
            end
            else if (early || short)
            begin
                status = cset_pkg::ST_ORDER;
            end
            else
            begin
                status = cset_pkg::ST_FINISHED;
                pop    = 1'b1;
            end
        end
    end

    assign stat.out_free    = !out_valid_reg || m_tready;
    assign stat.need_parent = pop && (level_reg > LVL_W'(1));

    assign sum        = {1'b0, rd_data_reg.callee} + {1'b0, incl_reg};
    assign callee_sat = sum[CALLEE_W] ? '1 : sum[CALLEE_W-1:0];

    // capture the event payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg <= s_tuser;
            id_reg <= s_tdata[ID_W-1:0];
            ts_reg <= s_tdata[ID_W +: TIME_W];
        end
    end

    // frame memory below the top frame
    always_ff @(posedge clk)
    begin
        if (cmd.commit && push && !empty)
        begin
            mem[lvl_m1[ADDR_W-1:0]] <= top_reg;
        end
        if (cmd.commit && stat.need_parent)
        begin
            rd_data_reg <= mem[lvl_m2[ADDR_W-1:0]];
        end
    end

    // cached top frame and inclusive time of the popped call
    always_ff @(posedge clk)
    begin
        if (cmd.commit && push)
        begin
            top_reg <= '{id: id_reg, start: ts_reg, callee: '0};
        end
        else if (cmd.load_parent)
        begin
            top_reg <= '{id: rd_data_reg.id, start: rd_data_reg.start, callee: callee_sat};
        end
        if (cmd.commit && pop)
        begin
            incl_reg <= incl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else if (cmd.commit && push)
        begin
            level_reg <= level_reg + LVL_W'(1);
        end
        else if (cmd.commit && pop)
        begin
            level_reg <= lvl_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_status_reg <= status;
            out_id_reg     <= id_reg;
            out_excl_reg   <= pop ? excl : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = cset_pkg::M_TDATA_W'({out_excl_reg, out_id_reg});

endmodule

`default_nettype wire

>>> src/call_stack_exclusive_time_core.sv
// ----------------------------------------------------------------------------
// call_stack_exclusive_time_core
// Call stack profiler: start/stop events in, one status transaction out each.
// ----------------------------------------------------------------------------
// Input channel s_*: tuser carries op (0 start, 1 stop); tdata carries
// func_id [7:0] and timestamp [23:8]. Output channel m_*: tuser carries the
// status code; tdata carries done_id [7:0] and exclusive_time [24:8].
// Every input transaction yields exactly one output transaction.
// An event is taken in the idle state and evaluated in the exec state once
// the output register is free; on commit its result is registered there.
// Only a stop that leaves a parent frame goes on to the load state: the
// parent is read from the one-port frame memory and written back to the
// top-frame registers with its callee time; s_tready is high only in idle.
// The top frame lives in registers; deeper frames live in the frame memory.
// Reset empties the stack and the output register; frame contents are not
// cleared. When the receiver stalls, the result holds in the output register
// and the next event is still taken; its evaluation waits until the held
// result is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module call_stack_exclusive_time_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [cset_pkg::S_TDATA_W-1:0] s_tdata,  // func_id, timestamp
    input  wire logic                           s_tuser,  // op
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [cset_pkg::M_TDATA_W-1:0]      m_tdata,  // done_id, exclusive_time, pad
    output logic [cset_pkg::STATUS_W-1:0]       m_tuser   // status
);

    cset_pkg::cmd_t  cmd;
    cset_pkg::stat_t stat;

    cset_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cset_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire

>>> src/cset_checker.sv
// ----------------------------------------------------------------------------
// cset_checker
// Port-level checks of the call stack core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cset_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [cset_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic [cset_pkg::STATUS_W-1:0]  m_tuser
);

    logic                          excl_zero;
    logic                          code_ok;

    assign excl_zero = (m_tdata[cset_pkg::ID_W +: cset_pkg::CALLEE_W] == '0);
    assign code_ok   = (m_tuser == cset_pkg::ST_STARTED)  || (m_tuser == cset_pkg::ST_FINISHED)
                    || (m_tuser == cset_pkg::ST_MISMATCH) || (m_tuser == cset_pkg::ST_EMPTY)
                    || (m_tuser == cset_pkg::ST_OVERFLOW) || (m_tuser == cset_pkg::ST_ORDER);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output transaction changed")
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready, "input taken while an event is in flight")
    `ASSERT_IMPL(a_code_valid, clk, rst_n, m_tvalid, code_ok, "status code out of range")
    `ASSERT_IMPL(a_excl_zero, clk, rst_n, m_tvalid && (m_tuser != cset_pkg::ST_FINISHED), excl_zero, "exclusive time not zero on non-finish")

endmodule

bind call_stack_exclusive_time_core cset_checker u_cset_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the call stack exclusive time core.
// Start and stop events go in on the slave stream. A local call stack
// predicts the status, id and exclusive time of every event. Each output
// transaction is compared with the oldest prediction. Directed cases come
// first: stop on empty, mismatch, out of order and overflow. Random
// nested call traces with some noise follow, under changing idle and
// stall patterns and one long output hold; callee saturation comes last.
// ----------------------------------------------------------------------------

module tb;

    localparam logic OP_START    = 1'b0;
    localparam logic OP_STOP     = 1'b1;
    localparam int   CALLEE_MAX  = (1 << cset_pkg::CALLEE_W) - 1;
    localparam int   STALL_LIMIT = 3000;
    localparam int   REPORT_MAX  = 10;

    typedef struct packed {
        cset_pkg::status_t               status;
        logic [cset_pkg::ID_W-1:0]       id;
        logic [cset_pkg::CALLEE_W-1:0]   excl;
    } result_t;

    logic                              clk;
    logic                              rst_n    = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [cset_pkg::S_TDATA_W-1:0]    s_tdata  = '0;  // func_id, timestamp
    logic                              s_tuser  = 1'b0; // op
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [cset_pkg::M_TDATA_W-1:0]    m_tdata;        // done_id, exclusive_time, pad
    logic [cset_pkg::STATUS_W-1:0]     m_tuser;        // status

    cset_pkg::frame_t        frames [cset_pkg::STACK_DEPTH];
    int                      call_depth;
    int                      deepest;
    cset_pkg::status_t       last_status;
    result_t                 expected_results [$];

    int                      src_idle_pct;
    int                      sink_idle_pct;
    int                      hold_request;
    int                      clock_now;
    bit                      after_stop;
    int                      events_sent;
    int                      results_seen;
    int                      fail_count;
    int                      status_seen [6];

    call_stack_exclusive_time_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void account_event(input logic op,
                                          input logic [cset_pkg::ID_W-1:0] id,
                                          input logic [cset_pkg::TIME_BITS-1:0] ts);
        result_t r;
        int      incl;
        int      sum;
        int      top;
        r.status = cset_pkg::ST_STARTED;
        r.id     = id;
        r.excl   = '0;
        top      = call_depth - 1;
        if (op == OP_START)
        begin
            if (call_depth >= cset_pkg::STACK_DEPTH)
                r.status = cset_pkg::ST_OVERFLOW;
            else if (call_depth > 0 && ts < frames[top].start)
                r.status = cset_pkg::ST_ORDER;
            else
            begin
                frames[call_depth].id     = id;
                frames[call_depth].start  = ts;
                frames[call_depth].callee = '0;
                call_depth++;
                if (call_depth > deepest)
                    deepest = call_depth;
            end
        end
        else if (call_depth == 0)
            r.status = cset_pkg::ST_EMPTY;
        else if (frames[top].id != id)
            r.status = cset_pkg::ST_MISMATCH;
        else
        begin
            incl = int'(ts) - int'(frames[top].start) + 1;
            if (ts < frames[top].start || incl < int'(frames[top].callee))
                r.status = cset_pkg::ST_ORDER;
            else
            begin
                r.status = cset_pkg::ST_FINISHED;
                r.excl   = cset_pkg::CALLEE_W'(incl - int'(frames[top].callee));
                call_depth--;
                if (call_depth > 0)
                begin
                    sum = int'(frames[top-1].callee) + incl;
                    frames[top-1].callee = (sum > CALLEE_MAX)
                                           ? cset_pkg::CALLEE_W'(CALLEE_MAX)
                                           : cset_pkg::CALLEE_W'(sum);
                end
            end
        end
        last_status = r.status;
        expected_results.push_back(r);
    endfunction

    function automatic void check_result();
        result_t                       want;
        logic [cset_pkg::ID_W-1:0]     got_id;
        logic [cset_pkg::CALLEE_W-1:0] got_excl;
        got_id   = m_tdata[cset_pkg::ID_W-1:0];
        got_excl = m_tdata[cset_pkg::ID_W +: cset_pkg::CALLEE_W];
        results_seen++;
        if (m_tuser < 6)
            status_seen[m_tuser]++;
        if (expected_results.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("ERROR: unexpected result status %0d id %0d time %0d",
                         m_tuser, got_id, got_excl);
            return;
        end
        want = expected_results.pop_front();
        if (m_tuser !== want.status || got_id !== want.id || got_excl !== want.excl)
        begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("ERROR: result %0d exp %0d %0d %0d, got %0d %0d %0d",
                         results_seen, want.status, want.id, want.excl,
                         m_tuser, got_id, got_excl);
        end
    endfunction

    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_result();
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= (int'($urandom_range(99)) >= sink_idle_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_event(input logic op, input logic [cset_pkg::ID_W-1:0] id,
                              input logic [cset_pkg::TIME_BITS-1:0] ts);
        while (int'($urandom_range(99)) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {ts, id};
        do
            @(posedge clk);
        while (!s_tready);
        account_event(op, id, ts);
        events_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic void step_clock(input int min_step);
        clock_now = clock_now + int'($urandom_range(min_step, 40));
        if (clock_now > 65535)
            clock_now = 65535;
    endfunction

    task automatic test_stop_on_empty();
        send_event(OP_STOP, 8'h00, 16'h0000);
        send_event(OP_STOP, 8'hFF, 16'hFFFF);
    endtask

    task automatic test_nested_calls();
        send_event(OP_START, 8'h00, 16'd0);
        send_event(OP_START, 8'hFF, 16'd10);
        send_event(OP_STOP,  8'h00, 16'd20);
        send_event(OP_STOP,  8'hFF, 16'd5);
        send_event(OP_START, 8'h5A, 16'd5);
        send_event(OP_STOP,  8'hFF, 16'd20);
        send_event(OP_STOP,  8'h00, 16'd30);
    endtask

    task automatic test_callee_exceeds_span();
        send_event(OP_START, 8'h11, 16'd100);
        send_event(OP_START, 8'h22, 16'd100);
        send_event(OP_STOP,  8'h22, 16'd200);
        send_event(OP_STOP,  8'h11, 16'd150);
        send_event(OP_STOP,  8'h11, 16'd200);
    endtask

    task automatic test_stack_overflow();
        for (int i = 0; i < cset_pkg::STACK_DEPTH; i++)
            send_event(OP_START, cset_pkg::ID_W'(i * 17),
                       cset_pkg::TIME_BITS'(65535 - cset_pkg::STACK_DEPTH + 1 + i));
        send_event(OP_START, 8'hA5, 16'hFFFF);
        for (int i = cset_pkg::STACK_DEPTH - 1; i >= 0; i--)
            send_event(OP_STOP, cset_pkg::ID_W'(i * 17), 16'hFFFF);
    endtask

    task automatic test_random_traffic(input int count, input int src_pct, input int sink_pct);
        int unsigned                     pick;
        logic                            op;
        logic [cset_pkg::ID_W-1:0]       id;
        logic [cset_pkg::TIME_BITS-1:0]  ts;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (call_depth > 0 && clock_now < int'(frames[call_depth-1].start))
                clock_now = int'(frames[call_depth-1].start);
            if (pick < 10)
            begin
                op = 1'($urandom_range(1));
                id = cset_pkg::ID_W'($urandom());
                ts = cset_pkg::TIME_BITS'($urandom());
                if (op == OP_START && call_depth > 0 && ts >= frames[call_depth-1].start
                    && int'(ts) <= clock_now)
                    ts = cset_pkg::TIME_BITS'(clock_now + 1);
            end
            else if (call_depth == 0)
            begin
                if (clock_now > 50000 || $urandom_range(3) == 0)
                    clock_now = int'($urandom_range(40000));
                step_clock(after_stop ? 1 : 0);
                op = (pick < 14) ? OP_STOP : OP_START;
                id = cset_pkg::ID_W'($urandom());
                ts = cset_pkg::TIME_BITS'(clock_now);
            end
            else if (call_depth == cset_pkg::STACK_DEPTH && pick < 20)
            begin
                op = OP_START;
                id = cset_pkg::ID_W'($urandom());
                ts = cset_pkg::TIME_BITS'(clock_now);
            end
            else if (clock_now < 60000 && call_depth < cset_pkg::STACK_DEPTH
                     && $urandom_range(99) < 55)
            begin
                step_clock(after_stop ? 1 : 0);
                op = OP_START;
                id = cset_pkg::ID_W'($urandom());
                ts = cset_pkg::TIME_BITS'(clock_now);
            end
            else
            begin
                step_clock(0);
                op = OP_STOP;
                id = frames[call_depth-1].id;
                ts = cset_pkg::TIME_BITS'(clock_now);
            end
            send_event(op, id, ts);
            if (last_status == cset_pkg::ST_STARTED || last_status == cset_pkg::ST_FINISHED)
            begin
                if (int'(ts) > clock_now)
                    clock_now = int'(ts);
                after_stop = (last_status == cset_pkg::ST_FINISHED);
            end
        end
    endtask

    task automatic test_output_hold();
        hold_request = 300;
        test_random_traffic(24, 0, 0);
        wait_for_results();
    endtask

    task automatic test_callee_saturation();
        while (call_depth > 0)
        begin
            send_event(OP_STOP, frames[call_depth-1].id, 16'hFFFF);
            if (last_status != cset_pkg::ST_FINISHED)
                break;
        end
        send_event(OP_START, 8'h01, 16'h0000);
        send_event(OP_START, 8'h02, 16'h0000);
        send_event(OP_STOP,  8'h02, 16'hFFFF);
        send_event(OP_START, 8'h03, 16'h0000);
        send_event(OP_STOP,  8'h03, 16'hFFFF);
        send_event(OP_STOP,  8'h01, 16'hFFFF);
    endtask

    initial
    begin
        call_depth    = 0;
        deepest       = 0;
        clock_now     = 0;
        after_stop    = 1'b0;
        hold_request  = 0;
        src_idle_pct  = 30;
        sink_idle_pct = 76;
        events_sent   = 0;
        results_seen  = 0;
        fail_count    = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_stop_on_empty();
        test_nested_calls();
        test_callee_exceeds_span();
        test_stack_overflow();
        test_random_traffic(525, 30, 76);
        wait_for_results();
        test_random_traffic(525, 76, 30);
        wait_for_results();
        test_output_hold();
        test_random_traffic(525, 0, 0);
        wait_for_results();
        test_callee_saturation();
        wait_for_results();
        repeat (20) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            fail_count++;
            $display("ERROR: %0d results never arrived", expected_results.size());
        end
        $display("Sent %0d events, checked %0d results, deepest stack %0d of %0d",
                 events_sent, results_seen, deepest, cset_pkg::STACK_DEPTH);
        $display("Statuses: %0d started, %0d finished, %0d mismatch, %0d empty,",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        $display("  %0d overflow, %0d order; %0d errors",
                 status_seen[4], status_seen[5], fail_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> call_stack_exclusive_time_core.f
+incdir+src
src/cset_pkg.sv
src/cset_ctrl.sv
src/cset_dp.sv
src/call_stack_exclusive_time_core.sv
src/cset_checker.sv
tb/sv/tb.sv
